>>> hdl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PSP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define PSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hdl/psp_pkg.sv
// Types and constants of the pedal sensor plausibility block.
package psp_pkg;

   localparam int SAMPLE_W    = 12;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 32;

   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   localparam logic [2:0] REG_OFFSET_ONE     = 3'd0;
   localparam logic [2:0] REG_OFFSET_TWO     = 3'd1;
   localparam logic [2:0] REG_RECIP_SPAN_ONE = 3'd2;
   localparam logic [2:0] REG_RECIP_SPAN_TWO = 3'd3;
   localparam logic [2:0] REG_GAIN_ONE       = 3'd4;
   localparam logic [2:0] REG_GAIN_TWO       = 3'd5;
   localparam logic [2:0] REG_DIFF_THRESHOLD = 3'd6;
   localparam logic [2:0] REG_POSITION_MAX   = 3'd7;

   localparam int DIFF_SCALE = 1000;
   localparam int DIFF_SAT   = 120;
   localparam int Q16_ONE    = 65536;
   // smallest Q16 difference whose scaled value exceeds the saturation level
   localparam int DIFF_SAT_LIMIT = ((DIFF_SAT + 1) * Q16_ONE + DIFF_SCALE - 1) / DIFF_SCALE;
   localparam int DIFF_LO_W  = 13;
   localparam int ROUND_HALF = 32768;
   localparam int FRAME_WRAP = 100;

   typedef struct packed {
      logic [11:0] offset_one;
      logic [11:0] offset_two;
      logic [23:0] recip_span_one;
      logic [23:0] recip_span_two;
      logic [23:0] gain_one;
      logic [23:0] gain_two;
      logic [15:0] diff_threshold;
      logic [15:0] position_max;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic ring_read;
      logic ring_write;
      logic div_start;
      logic mul_load;
      logic diff_load;
      logic fin_commit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

>>> hdl/psp_ctrl.sv
// Sequencer for store and evaluate transactions.
module psp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tuser,
   output logic                 req_tready,
   input  psp_pkg::status_type  status,
   output psp_pkg::cmd_type     cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_WRITE = 3'd2;
   localparam logic [2:0] ST_MUL = 3'd3;
   localparam logic [2:0] ST_DIFF = 3'd4;
   localparam logic [2:0] ST_FIN = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic             accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = accept;
            if (accept) begin
               if (req_tuser == psp_pkg::CMD_EVAL) begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_MUL;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.ring_read = 1'b1;
            state_in      = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.ring_write = 1'b1;
            state_in       = ST_IDLE;
         end
         ST_MUL: begin
            cmd.mul_load = 1'b1;
            state_in     = ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff_load = 1'b1;
            state_in      = ST_FIN;
         end
         ST_FIN: begin
            if (status.out_free) begin
               cmd.fin_commit = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/psp_datapath.sv
// Sample ring, running sums, averaging, scaling and plausibility datapath.
module psp_datapath #(
   parameter int WINDOW = 50
) (
   input  logic                              clock,
   input  logic                              reset,
   input  psp_pkg::cmd_type                  cmd,
   input  psp_pkg::cfg_type                  cfg,
   input  logic [psp_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              rsp_tready,
   output psp_pkg::status_type               status,
   output logic                              rsp_tvalid,
   output logic [psp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tuser
);

   localparam int SW    = psp_pkg::SAMPLE_W;
   localparam int PTR_W = $clog2(WINDOW);
   localparam int SUM_W = SW + $clog2(WINDOW);
   localparam int LO_W  = psp_pkg::DIFF_LO_W;
   // sum / WINDOW as (sum * RCP_MUL) >> RCP_SH, exact for every sum below 2**SUM_W
   localparam int RCP_SH  = SUM_W + $clog2(WINDOW);
   localparam int RCP_MUL = ((1 << RCP_SH) + WINDOW - 1) / WINDOW;
   localparam int RCP_W   = SUM_W + 1;
   localparam int QP_W    = SUM_W + RCP_W;

   // ring
   logic [2*SW-1:0]  ring_mem [WINDOW];
   logic [WINDOW-1:0] valid_ff;
   logic [2*SW-1:0]  old_ff;
   logic             old_valid_ff;
   logic [PTR_W-1:0] ptr_ff, ptr_in;

   // lanes
   logic [SW-1:0]    smp_ff [2];
   logic [SUM_W-1:0] sum_ff [2];
   logic [SUM_W-1:0] sum_in [2];
   logic [SW-1:0]    quo_ff [2];
   logic [SW-1:0]    quo_in [2];
   logic signed [37:0] nprod_ff [2];
   logic signed [37:0] nprod_in [2];
   logic [35:0]      gprod_ff [2];
   logic [35:0]      gprod_in [2];
   logic             pos_ff [2];
   logic             pos_in [2];
   logic [15:0]      tpos_ff [2];
   logic [15:0]      tpos_in [2];
   logic [SW-1:0]    offset [2];
   logic [23:0]      recip [2];
   logic [23:0]      gain [2];

   logic [29:0]      dabs_ff, dabs_in;

   // result state
   logic             last_plaus_ff, last_plaus_in;
   logic             fault_ff, fault_in;
   logic [6:0]       frozen_ff, frozen_in;
   logic [6:0]       frame_ff, frame_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [psp_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_user_ff, rsp_user_in;

   assign offset[0] = cfg.offset_one;
   assign offset[1] = cfg.offset_two;
   assign recip[0]  = cfg.recip_span_one;
   assign recip[1]  = cfg.recip_span_two;
   assign gain[0]   = cfg.gain_one;
   assign gain[1]   = cfg.gain_two;

   assign status.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   assign ptr_in = (ptr_ff == PTR_W'(WINDOW - 1)) ? '0 : ptr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (cmd.ring_write) begin
         ring_mem[ptr_ff] <= {smp_ff[1], smp_ff[0]};
      end
      if (cmd.ring_read) begin
         old_ff       <= ring_mem[ptr_ff];
         old_valid_ff <= valid_ff[ptr_ff];
      end
   end

   always_comb begin
      logic [SW-1:0]      old_s;
      logic [QP_W-1:0]    qprod;
      logic [SW-1:0]      avg;
      logic signed [12:0] vdiff;
      logic [36:0]        gsum;
      logic [20:0]        rnd;
      for (int l = 0; l < 2; l++) begin
         old_s = old_valid_ff ? old_ff[l*SW +: SW] : '0;
         sum_in[l] = sum_ff[l] - SUM_W'(old_s) + SUM_W'(smp_ff[l]);

         qprod     = QP_W'(sum_ff[l]) * QP_W'(RCP_MUL);
         quo_in[l] = qprod[RCP_SH +: SW];

         avg         = quo_ff[l];
         vdiff       = $signed({1'b0, avg}) - $signed({1'b0, offset[l]});
         nprod_in[l] = vdiff * $signed({1'b0, recip[l]});
         gprod_in[l] = 36'(avg - offset[l]) * 36'(gain[l]);
         pos_in[l]   = (avg > offset[l]);

         gsum = 37'(gprod_ff[l]) + 37'(psp_pkg::ROUND_HALF);
         rnd  = gsum[36:16];
         if (!pos_ff[l]) begin
            tpos_in[l] = '0;
         end else if (rnd > 21'(cfg.position_max)) begin
            tpos_in[l] = cfg.position_max;
         end else begin
            tpos_in[l] = rnd[15:0];
         end
      end
   end

   always_comb begin
      logic signed [29:0] p0;
      logic signed [29:0] p1;
      logic signed [30:0] dif;
      p0  = nprod_ff[0][37:8];
      p1  = nprod_ff[1][37:8];
      dif = 31'(p0) - 31'(p1);
      dabs_in = (dif < 0) ? 30'(-dif) : 30'(dif);
   end

   always_comb begin
      logic [22:0] dm;
      logic [6:0]  diffv;
      logic        plaus;
      logic [16:0] psum;
      logic [15:0] pedal;
      dm    = 23'(dabs_ff[LO_W-1:0]) * 23'(psp_pkg::DIFF_SCALE);
      diffv = (dabs_ff >= 30'(psp_pkg::DIFF_SAT_LIMIT)) ? 7'(psp_pkg::DIFF_SAT) : dm[22:16];
      plaus = !(dabs_ff > 30'(cfg.diff_threshold));
      psum  = 17'(tpos_ff[0]) + 17'(tpos_ff[1]);
      pedal = psum[16:1];
      frame_in = (frame_ff == 7'(psp_pkg::FRAME_WRAP - 1)) ? '0 : frame_ff + 1'b1;

      last_plaus_in = last_plaus_ff;
      fault_in      = fault_ff;
      frozen_in     = frozen_ff;
      rsp_user_in   = 1'b1;
      rsp_data_in   = {2'b00, frozen_ff, frame_in, 16'h0000};
      if (!fault_ff) begin
         if (!plaus && !last_plaus_ff) begin
            fault_in    = 1'b1;
            frozen_in   = diffv;
            rsp_data_in = {2'b00, diffv, frame_in, 16'h0000};
         end else begin
            last_plaus_in = plaus;
            rsp_user_in   = 1'b0;
            rsp_data_in   = {2'b00, diffv, frame_in, pedal};
         end
      end

      if (cmd.fin_commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         smp_ff[0] <= req_tdata[SW-1:0];
         smp_ff[1] <= req_tdata[2*SW-1:SW];
      end
      for (int l = 0; l < 2; l++) begin
         if (cmd.div_start) begin
            quo_ff[l] <= quo_in[l];
         end
         if (cmd.mul_load) begin
            nprod_ff[l] <= nprod_in[l];
            gprod_ff[l] <= gprod_in[l];
            pos_ff[l]   <= pos_in[l];
         end
         if (cmd.diff_load) begin
            tpos_ff[l] <= tpos_in[l];
         end
      end
      if (cmd.diff_load) begin
         dabs_ff <= dabs_in;
      end
      if (cmd.fin_commit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         ptr_ff        <= '0;
         sum_ff[0]     <= '0;
         sum_ff[1]     <= '0;
         last_plaus_ff <= 1'b1;
         fault_ff      <= 1'b0;
         frozen_ff     <= '0;
         frame_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.ring_write) begin
            valid_ff[ptr_ff] <= 1'b1;
            ptr_ff           <= ptr_in;
            sum_ff[0]        <= sum_in[0];
            sum_ff[1]        <= sum_in[1];
         end
         if (cmd.fin_commit) begin
            last_plaus_ff <= last_plaus_in;
            fault_ff      <= fault_in;
            frozen_ff     <= frozen_in;
            frame_ff      <= frame_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hdl/pedal_sensor_plausibility.sv
// Top level of the pedal sensor plausibility block: register file and wiring.
//
//   port group | dir | payload
//   req_       | in  | tdata: sample_one, sample_two; tuser: command
//   rsp_       | out | tdata: pedal_pos, frame_count, sensor_gap; tuser: implausible
//   csr_       | cfg | APB registers 0..7 at byte address 4*i
//
// A store transaction steps through accept, ring read, then ring write and sum update.
// An evaluate steps through accept, where both averages are formed by multiplying
// the sums with the reciprocal of WINDOW, then products, then difference and scaled
// positions, then the step that loads the result register.
// Reset clears the ring valid bits, sums and fault state at once; no clearing pass.
// An evaluate holds in its final step while an earlier result is not yet taken.
module pedal_sensor_plausibility #(
   parameter int WINDOW = 50
) (
   input  logic                              clock,
   input  logic                              reset,
   // sample_one [11:0], sample_two [23:12]
   input  logic [psp_pkg::REQ_DATA_W-1:0]    req_tdata,
   // command [0]
   input  logic                              req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pedal_pos [15:0], frame_count [22:16], sensor_gap [29:23], zero [31:30]
   output logic [psp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // implausible [0]
   output logic                              rsp_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [psp_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [psp_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [psp_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   psp_pkg::cfg_type    cfg_ff, cfg_in;
   psp_pkg::cmd_type    cmd;
   psp_pkg::status_type status;
   logic [2:0]          csr_index;
   logic                csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            psp_pkg::REG_OFFSET_ONE:     cfg_in.offset_one     = csr_pwdata[11:0];
            psp_pkg::REG_OFFSET_TWO:     cfg_in.offset_two     = csr_pwdata[11:0];
            psp_pkg::REG_RECIP_SPAN_ONE: cfg_in.recip_span_one = csr_pwdata[23:0];
            psp_pkg::REG_RECIP_SPAN_TWO: cfg_in.recip_span_two = csr_pwdata[23:0];
            psp_pkg::REG_GAIN_ONE:       cfg_in.gain_one       = csr_pwdata[23:0];
            psp_pkg::REG_GAIN_TWO:       cfg_in.gain_two       = csr_pwdata[23:0];
            psp_pkg::REG_DIFF_THRESHOLD: cfg_in.diff_threshold = csr_pwdata[15:0];
            psp_pkg::REG_POSITION_MAX:   cfg_in.position_max   = csr_pwdata[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         psp_pkg::REG_OFFSET_ONE:     csr_prdata = 32'(cfg_ff.offset_one);
         psp_pkg::REG_OFFSET_TWO:     csr_prdata = 32'(cfg_ff.offset_two);
         psp_pkg::REG_RECIP_SPAN_ONE: csr_prdata = 32'(cfg_ff.recip_span_one);
         psp_pkg::REG_RECIP_SPAN_TWO: csr_prdata = 32'(cfg_ff.recip_span_two);
         psp_pkg::REG_GAIN_ONE:       csr_prdata = 32'(cfg_ff.gain_one);
         psp_pkg::REG_GAIN_TWO:       csr_prdata = 32'(cfg_ff.gain_two);
         psp_pkg::REG_DIFF_THRESHOLD: csr_prdata = 32'(cfg_ff.diff_threshold);
         psp_pkg::REG_POSITION_MAX:   csr_prdata = 32'(cfg_ff.position_max);
         default:                     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset_one     <= 12'd0;
         cfg_ff.offset_two     <= 12'd0;
         cfg_ff.recip_span_one <= 24'd8192;
         cfg_ff.recip_span_two <= 24'd8192;
         cfg_ff.gain_one       <= 24'd32768;
         cfg_ff.gain_two       <= 24'd32768;
         cfg_ff.diff_threshold <= 16'd6554;
         cfg_ff.position_max   <= 16'd1000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   psp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   psp_datapath #(
      .WINDOW (WINDOW)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg_ff),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

>>> hdl/psp_checker.sv
// Port-level checker for the pedal sensor plausibility block, with its bind.
`include "assert_macros.svh"

module psp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [psp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser
);

   logic fault_seen_ff, fault_seen_in;

   assign fault_seen_in = fault_seen_ff || (rsp_tvalid && rsp_tready && rsp_tuser);

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_seen_ff <= 1'b0;
      end else begin
         fault_seen_ff <= fault_seen_in;
      end
   end

   // stalled result transaction holds
   `PSP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   // one input transaction at a time
   `PSP_ASSERT_NEXT(a_req_busy, clock, reset, req_tvalid && req_tready, !req_tready)
   // fault frames carry zero pedal
   `PSP_ASSERT_NOW(a_fault_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[15:0] == 16'h0000)
   // fault is sticky
   `PSP_ASSERT_NOW(a_fault_sticky, clock, reset, rsp_tvalid && fault_seen_ff, rsp_tuser)
   // frame counter and difference in range
   `PSP_ASSERT_NOW(a_ranges, clock, reset, rsp_tvalid, (rsp_tdata[22:16] <= 7'd99) && (rsp_tdata[29:23] <= 7'd120))

endmodule

bind pedal_sensor_plausibility psp_checker u_checker (.*);
